FILE: hw/rtl/c2s_pkg.sv
`timescale 1ns / 1ps
package c2s_pkg;

  // datapath sizes of the normalised CORDIC and the root extraction
  localparam int DATA_W       = 64;
  localparam int ACC_W        = 64;
  localparam int CORDIC_ITERS = 60;
  localparam int SQRT_STEPS   = 32;
  localparam int RAD_DELAY    = CORDIC_ITERS - SQRT_STEPS;
  localparam int NORM_MSB     = 57;
  localparam int SHIFT_W      = 6;

  // result and register sizes
  localparam int RADIUS_W = 16;
  localparam int BAND_W   = 11;
  localparam int APB_W    = 32;
  localparam int ADDR_W   = 3;

  localparam logic [BAND_W-1:0]   BAND_RESET = BAND_W'(1);
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

  // register indexes
  localparam logic [0:0] REG_ZERO_BAND = 1'b0;

  // half a turn on the accumulator
  localparam logic [ACC_W-1:0] HALF_TURN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic all_zero;
    logic xy_zero;
    logic z_pos;
  } pt_flags_t;

  typedef logic [ACC_W-1:0] turn_tab_t [CORDIC_ITERS];

  // shift-subtract division, used only while building the table
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent power series in integer arithmetic
  function automatic logic [63:0] atan_series(input logic [63:0] p_in, input int sh,
                                              input logic [63:0] dv);
    logic [63:0] p;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] k;
    logic [63:0] term;
    p   = p_in;
    pos = '0;
    neg = '0;
    k   = '0;
    while (p != 0) begin
      term = udiv(p, 2 * k + 1);
      if (k[0] == 1'b0) pos = pos + term;
      else neg = neg + term;
      p = udiv((sh < 64) ? (p >> sh) : 64'd0, dv);
      k = k + 1;
    end
    return pos - neg;
  endfunction

  function automatic logic [63:0] frac61(input logic [63:0] a, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = a;
    for (int n = 0; n < 61; n++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in 2^-64 turn, truncated
  function automatic turn_tab_t build_turn_tab();
    turn_tab_t   t;
    logic [63:0] qpi;
    qpi = 4 * atan_series(udiv(64'd1 << 62, 64'd5), 0, 64'd25)
        - atan_series(udiv(64'd1 << 62, 64'd239), 0, 64'd57121);
    t[0] = 64'd1 << 61;
    for (int i = 1; i < CORDIC_ITERS; i++)
      t[i] = frac61(atan_series(64'd1 << (62 - i), 2 * i, 64'd1), qpi);
    return t;
  endfunction

  localparam turn_tab_t TURN_TAB = build_turn_tab();

endpackage

FILE: hw/rtl/c2s_ifs.sv
`timescale 1ns / 1ps
// point channel
interface c2s_point_if #(parameter int COORD_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  coord_x;
  logic signed [COORD_WIDTH-1:0]  coord_y;
  logic signed [COORD_WIDTH-1:0]  coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

// spherical result channel
interface c2s_sphere_if #(parameter int ANGLE_WIDTH = 16);
  logic                    valid;
  logic                    ready;
  logic [15:0]             radius;
  logic [ANGLE_WIDTH-1:0]  azimuth;
  logic [ANGLE_WIDTH-1:0]  polar;

  modport source (output valid, radius, azimuth, polar, input ready);
  modport sink   (input valid, radius, azimuth, polar, output ready);
endinterface

FILE: hw/rtl/c2s_cordic_cell.sv
`timescale 1ns / 1ps
module c2s_cordic_cell import c2s_pkg::*; #(
  parameter int STEP   = 0,
  parameter int PASS_W = 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] in_a,
  input  logic signed [DATA_W-1:0] in_b,
  input  logic [ACC_W-1:0]         in_acc,
  input  logic [PASS_W-1:0]        in_pass,
  output logic signed [DATA_W-1:0] out_a,
  output logic signed [DATA_W-1:0] out_b,
  output logic [ACC_W-1:0]         out_acc,
  output logic [PASS_W-1:0]        out_pass
);

  logic signed [DATA_W-1:0] dx, dy, a_next, b_next;
  logic [ACC_W-1:0]         acc_next;

  // one micro-rotation towards the x axis
  always_comb begin
    dx = in_b >>> STEP;
    dy = in_a >>> STEP;
    if (!in_b[DATA_W-1]) begin
      a_next   = in_a + dx;
      b_next   = in_b - dy;
      acc_next = in_acc + TURN_TAB[STEP];
    end else begin
      a_next   = in_a - dx;
      b_next   = in_b + dy;
      acc_next = in_acc - TURN_TAB[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_a    <= a_next;
      out_b    <= b_next;
      out_acc  <= acc_next;
      out_pass <= in_pass;
    end
  end

endmodule

FILE: hw/rtl/c2s_sqrt_cell.sv
`timescale 1ns / 1ps
module c2s_sqrt_cell import c2s_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] in_rem,
  input  logic [DATA_W-1:0] in_res,
  output logic [DATA_W-1:0] out_rem,
  output logic [DATA_W-1:0] out_res
);

  localparam logic [DATA_W-1:0] BIT = DATA_W'(1) << (62 - 2 * STEP);

  logic [DATA_W-1:0] trial, rem_next, res_next;

  // one result bit of the digit-by-digit root
  always_comb begin
    trial = in_res + BIT;
    if (in_rem >= trial) begin
      rem_next = in_rem - trial;
      res_next = (in_res >> 1) + BIT;
    end else begin
      rem_next = in_rem;
      res_next = in_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem <= rem_next;
      out_res <= res_next;
    end
  end

endmodule

FILE: hw/rtl/cartesian_to_spherical_converter_unit.sv
`timescale 1ns / 1ps
// Cartesian to spherical converter. Each beat on the point channel carries one
// signed (x, y, z); each beat on the sphere channel returns its rounded radius,
// its azimuth atan2(y, x) in [0, one turn) and its polar angle from +z in
// [0, half turn], angles in 2^-ANGLE_WIDTH turn. Coordinates whose magnitude is
// below zero_band (APB register at address 0, reset 1) count as zero. The unit
// takes one point every cycle while its skid entry is empty. A result passes
// through four front stages, the two chains of 60 CORDIC cells run one after
// the other (azimuth, then polar), one hand-over stage and the output register.
// A two-entry output buffer lets the input keep flowing after the sink stalls,
// until its skid entry fills.
module cartesian_to_spherical_converter_unit import c2s_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  c2s_point_if.sink          point,
  c2s_sphere_if.source       sphere,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready
);

  localparam int CW    = COORD_WIDTH;
  localparam int CMPW  = (CW + 1 > BAND_W) ? CW + 1 : BAND_W;
  localparam int NV    = 4 + CORDIC_ITERS + 1 + CORDIC_ITERS;
  localparam int PFL_W = $bits(pt_flags_t);
  localparam int PB_W  = ACC_W + RADIUS_W + PFL_W;

  // configuration register
  logic [BAND_W-1:0] zero_band;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_ZERO_BAND) ? APB_W'(zero_band) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_band <= BAND_RESET;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_ZERO_BAND) begin
      zero_band <= pwdata[BAND_W-1:0];
    end
  end

  // pipeline advance and valid chain
  logic          en;
  logic          skid_valid;
  logic [NV-1:0] vld;

  assign en          = !skid_valid;
  assign point.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], point.valid};
    end
  end

  // magnitude of a coordinate
  function automatic logic [CW:0] mag_of(input logic signed [CW-1:0] c);
    return c[CW-1] ? (CW+1)'(-$signed({c[CW-1], c})) : {1'b0, c};
  endfunction

  // stage 0: capture
  logic signed [CW-1:0] x0, y0, z0;
  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= point.coord_x;
      y0 <= point.coord_y;
      z0 <= point.coord_z;
    end
  end

  // stage 1: dead band and magnitudes
  logic signed [CW-1:0] x1, y1, z1;
  logic [CW-1:0]        ax1, ay1, az1;
  logic [CW:0]          mx, my, mz;
  logic                 kx, ky, kz;

  always_comb begin
    mx = mag_of(x0);
    my = mag_of(y0);
    mz = mag_of(z0);
    kx = CMPW'(mx) >= CMPW'(zero_band);
    ky = CMPW'(my) >= CMPW'(zero_band);
    kz = CMPW'(mz) >= CMPW'(zero_band);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= kx ? x0 : '0;
      y1  <= ky ? y0 : '0;
      z1  <= kz ? z0 : '0;
      ax1 <= kx ? mx[CW-1:0] : '0;
      ay1 <= ky ? my[CW-1:0] : '0;
      az1 <= kz ? mz[CW-1:0] : '0;
    end
  end

  // stage 2: squares, largest magnitude and normalising shift
  logic signed [CW-1:0] x2, y2, z2;
  logic [2*CW-1:0]      sqx2, sqy2, sqz2;
  logic [SHIFT_W-1:0]   sh2;
  logic                 zero2;
  logic [CW-1:0]        m1;
  logic [SHIFT_W-1:0]   lead1;

  always_comb begin
    m1 = (ax1 > ay1) ? ax1 : ay1;
    if (az1 > m1) m1 = az1;
    lead1 = '0;
    for (int i = 0; i < CW; i++)
      if (m1[i]) lead1 = SHIFT_W'(i);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2    <= x1;
      y2    <= y1;
      z2    <= z1;
      sqx2  <= ax1 * ax1;
      sqy2  <= ay1 * ay1;
      sqz2  <= az1 * az1;
      sh2   <= SHIFT_W'(NORM_MSB) - lead1;
      zero2 <= (m1 == '0);
    end
  end

  // stage 3: sum of squares, scaling and CORDIC set-up
  logic signed [DATA_W-1:0] xs2, ys2, zs2;
  logic [DATA_W-1:0]        sum3;
  logic signed [DATA_W-1:0] aa3, ab3, ga3;
  logic [ACC_W-1:0]         aacc3;
  pt_flags_t                fl3;
  logic                     zneg3;

  always_comb begin
    xs2 = DATA_W'(x2) <<< sh2;
    ys2 = DATA_W'(y2) <<< sh2;
    zs2 = DATA_W'(z2) <<< sh2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3 <= DATA_W'(sqx2) + DATA_W'(sqy2) + DATA_W'(sqz2);
      if (xs2[DATA_W-1]) begin
        aa3   <= -xs2;
        ab3   <= -ys2;
        aacc3 <= HALF_TURN;
      end else begin
        aa3   <= xs2;
        ab3   <= ys2;
        aacc3 <= '0;
      end
      ga3          <= zs2[DATA_W-1] ? -zs2 : zs2;
      zneg3        <= z2[CW-1];
      fl3.all_zero <= zero2;
      fl3.xy_zero  <= (x2 == '0) && (y2 == '0);
      fl3.z_pos    <= !z2[CW-1];
    end
  end

  // azimuth chain, with the gain-matching rotation of |z| alongside
  logic signed [DATA_W-1:0] az_a [CORDIC_ITERS+1];
  logic signed [DATA_W-1:0] az_b [CORDIC_ITERS+1];
  logic [ACC_W-1:0]         az_acc [CORDIC_ITERS+1];
  logic [PFL_W-1:0]         az_fl [CORDIC_ITERS+1];
  logic signed [DATA_W-1:0] zg_a [CORDIC_ITERS+1];
  logic signed [DATA_W-1:0] zg_b [CORDIC_ITERS+1];
  logic [ACC_W-1:0]         zg_acc [CORDIC_ITERS+1];
  logic [0:0]               zg_neg [CORDIC_ITERS+1];

  assign az_a[0]   = aa3;
  assign az_b[0]   = ab3;
  assign az_acc[0] = aacc3;
  assign az_fl[0]  = fl3;
  assign zg_a[0]   = ga3;
  assign zg_b[0]   = '0;
  assign zg_acc[0] = '0;
  assign zg_neg[0] = zneg3;

  for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_az
    c2s_cordic_cell #(.STEP(k), .PASS_W(PFL_W)) u_az (
      .clk(clk), .en(en),
      .in_a(az_a[k]), .in_b(az_b[k]), .in_acc(az_acc[k]), .in_pass(az_fl[k]),
      .out_a(az_a[k+1]), .out_b(az_b[k+1]), .out_acc(az_acc[k+1]),
      .out_pass(az_fl[k+1])
    );
    c2s_cordic_cell #(.STEP(k), .PASS_W(1)) u_zg (
      .clk(clk), .en(en),
      .in_a(zg_a[k]), .in_b(zg_b[k]), .in_acc(zg_acc[k]), .in_pass(zg_neg[k]),
      .out_a(zg_a[k+1]), .out_b(zg_b[k+1]), .out_acc(zg_acc[k+1]),
      .out_pass(zg_neg[k+1])
    );
  end

  // radius: digit-by-digit root beside the azimuth chain
  logic [DATA_W-1:0] sq_rem [SQRT_STEPS+1];
  logic [DATA_W-1:0] sq_res [SQRT_STEPS+1];

  assign sq_rem[0] = sum3;
  assign sq_res[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
    c2s_sqrt_cell #(.STEP(k)) u_sq (
      .clk(clk), .en(en),
      .in_rem(sq_rem[k]), .in_res(sq_res[k]),
      .out_rem(sq_rem[k+1]), .out_res(sq_res[k+1])
    );
  end

  // round to nearest, saturate, then wait for the azimuth chain
  logic [DATA_W-1:0]   rad_full;
  logic [RADIUS_W-1:0] rad_fin;
  logic [RADIUS_W-1:0] rd [RAD_DELAY];

  always_comb begin
    rad_full = (sq_rem[SQRT_STEPS] > sq_res[SQRT_STEPS]) ?
               sq_res[SQRT_STEPS] + DATA_W'(1) : sq_res[SQRT_STEPS];
    rad_fin  = (rad_full > DATA_W'(RADIUS_MAX)) ? RADIUS_MAX : rad_full[RADIUS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd[0] <= rad_fin;
      for (int j = 1; j < RAD_DELAY; j++) rd[j] <= rd[j-1];
    end
  end

  // hand-over: polar vector (K*z, K*rxy), pre-rotated when z is negative
  logic signed [DATA_W-1:0] zk;
  logic signed [DATA_W-1:0] pa4, pb4;
  logic [ACC_W-1:0]         pacc4;
  logic [PB_W-1:0]          ppass4;

  assign zk = zg_neg[CORDIC_ITERS][0] ? -zg_a[CORDIC_ITERS] : zg_a[CORDIC_ITERS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zk[DATA_W-1]) begin
        pa4   <= -zk;
        pb4   <= -az_a[CORDIC_ITERS];
        pacc4 <= HALF_TURN;
      end else begin
        pa4   <= zk;
        pb4   <= az_a[CORDIC_ITERS];
        pacc4 <= '0;
      end
      ppass4 <= {az_acc[CORDIC_ITERS], rd[RAD_DELAY-1], az_fl[CORDIC_ITERS]};
    end
  end

  // polar chain
  logic signed [DATA_W-1:0] po_a [CORDIC_ITERS+1];
  logic signed [DATA_W-1:0] po_b [CORDIC_ITERS+1];
  logic [ACC_W-1:0]         po_acc [CORDIC_ITERS+1];
  logic [PB_W-1:0]          po_pass [CORDIC_ITERS+1];

  assign po_a[0]    = pa4;
  assign po_b[0]    = pb4;
  assign po_acc[0]  = pacc4;
  assign po_pass[0] = ppass4;

  for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_po
    c2s_cordic_cell #(.STEP(k), .PASS_W(PB_W)) u_po (
      .clk(clk), .en(en),
      .in_a(po_a[k]), .in_b(po_b[k]), .in_acc(po_acc[k]), .in_pass(po_pass[k]),
      .out_a(po_a[k+1]), .out_b(po_b[k+1]), .out_acc(po_acc[k+1]),
      .out_pass(po_pass[k+1])
    );
  end

  // final angle rounding and special cases
  logic [ACC_W-1:0]       azacc_f, azr, por;
  logic [RADIUS_W-1:0]    rad_f;
  pt_flags_t              fl_f;
  logic [ANGLE_WIDTH-1:0] azim_f, pol_f;
  logic                   deliver;

  always_comb begin
    {azacc_f, rad_f, fl_f} = po_pass[CORDIC_ITERS];
    azr = azacc_f + (ACC_W'(1) << (ACC_W - 1 - ANGLE_WIDTH));
    por = po_acc[CORDIC_ITERS] + (ACC_W'(1) << (ACC_W - 1 - ANGLE_WIDTH));
    if (fl_f.all_zero || fl_f.xy_zero) azim_f = '0;
    else azim_f = azr[ACC_W-1 -: ANGLE_WIDTH];
    priority if (fl_f.all_zero) pol_f = '0;
    else if (fl_f.xy_zero) pol_f = fl_f.z_pos ? '0 : {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
    else pol_f = por[ACC_W-1 -: ANGLE_WIDTH];
  end

  assign deliver = en && vld[NV-1];

  // output register with skid entry
  logic                   out_valid;
  logic [RADIUS_W-1:0]    out_rad, skid_rad;
  logic [ANGLE_WIDTH-1:0] out_az, skid_az, out_pol, skid_pol;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || sphere.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= deliver;
      end
    end else if (deliver) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || sphere.ready) begin
      if (skid_valid) begin
        out_rad <= skid_rad;
        out_az  <= skid_az;
        out_pol <= skid_pol;
      end else begin
        out_rad <= rad_f;
        out_az  <= azim_f;
        out_pol <= pol_f;
      end
    end else if (deliver) begin
      skid_rad <= rad_f;
      skid_az  <= azim_f;
      skid_pol <= pol_f;
    end
  end

  assign sphere.valid   = out_valid;
  assign sphere.radius  = out_rad;
  assign sphere.azimuth = out_az;
  assign sphere.polar   = out_pol;

endmodule

FILE: tb/sv/tb_cartesian_to_spherical_converter_unit.sv
`timescale 1ns / 1ps
module tb_cartesian_to_spherical_converter_unit;
  import c2s_pkg::*;

  localparam int ITERS     = 60;
  localparam int LATENCY   = 130;
  localparam int IDLE_MAX  = 4000;
  localparam int N_RANDOM  = 1400;

  typedef struct packed {
    logic [15:0] radius;
    logic [15:0] azimuth;
    logic [15:0] polar;
  } sphere_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    bit                 typed;
    sphere_t            res;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0]  pwdata = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  c2s_point_if  #(.COORD_WIDTH(16)) point ();
  c2s_sphere_if #(.ANGLE_WIDTH(16)) sphere ();

  cartesian_to_spherical_converter_unit uut (
    .clk(clk), .rst(rst), .point(point.sink), .sphere(sphere.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [63:0] atan_turn [ITERS];
  logic [10:0] band_cfg;
  sphere_t     sphere_q[$];
  int          n_errors = 0;
  int          idle_cycles = 0;
  bit          stall_free = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // arctangent series on unsigned 64-bit integers
  function automatic logic [63:0] atan_sum(logic [63:0] p, int sh, logic [63:0] dv);
    logic [63:0] pos, neg, k;
    pos = 0; neg = 0; k = 0;
    while (p != 0) begin
      if (k[0]) neg += p / (2 * k + 1);
      else pos += p / (2 * k + 1);
      p = ((sh < 64) ? (p >> sh) : 64'd0) / dv;
      k++;
    end
    return pos - neg;
  endfunction

  function automatic logic [63:0] turn_frac(logic [63:0] a, logic [63:0] d);
    logic [63:0] q, r;
    q = 0; r = a;
    for (int n = 0; n < 61; n++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r -= d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  task automatic fill_atan_turn();
    logic [63:0] qpi;
    qpi = 4 * atan_sum((64'd1 << 62) / 5, 0, 64'd25)
        - atan_sum((64'd1 << 62) / 239, 0, 64'd57121);
    atan_turn[0] = 64'd1 << 61;
    for (int i = 1; i < ITERS; i++)
      atan_turn[i] = turn_frac(atan_sum(64'd1 << (62 - i), 2 * i, 64'd1), qpi);
  endtask

  function automatic longint banded(logic signed [15:0] c);
    longint s, m;
    s = c;
    m = (s < 0) ? -s : s;
    return (m < longint'(band_cfg)) ? 0 : s;
  endfunction

  function automatic logic [63:0] root_rounded(logic [63:0] s);
    logic [63:0] res, bt, rem;
    res = 0; bt = 64'd1 << 62; rem = s;
    while (bt > rem) bt >>= 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem -= res + bt;
        res = (res >> 1) + bt;
      end else res >>= 1;
      bt >>= 2;
    end
    if (rem > res) res++;
    return res;
  endfunction

  // vectoring rotation: angle of (a, b) in 2^-64 turn, gain-scaled length in a
  function automatic logic [63:0] vector_angle(inout longint a, input longint b);
    longint xa, yb, dx, dy;
    logic [63:0] acc;
    xa = a; yb = b; acc = 0;
    if (xa < 0) begin
      xa = -xa; yb = -yb; acc = HALF_TURN;
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = yb >>> i;
      dy = xa >>> i;
      if (yb >= 0) begin
        xa += dx; yb -= dy; acc += atan_turn[i];
      end else begin
        xa -= dx; yb += dy; acc -= atan_turn[i];
      end
    end
    a = xa;
    return acc;
  endfunction

  function automatic logic [15:0] angle_lsb(logic [63:0] acc);
    logic [63:0] r;
    r = (acc + (64'd1 << 47)) >> 48;
    return r[15:0];
  endfunction

  function automatic sphere_t to_sphere(logic signed [15:0] cx, cy, cz);
    sphere_t o;
    longint x, y, z, ax, ay, az, m, xs, ys, zs, rxy, zk;
    logic [63:0] rad;
    int sh;
    x = banded(cx); y = banded(cy); z = banded(cz);
    ax = (x < 0) ? -x : x; ay = (y < 0) ? -y : y; az = (z < 0) ? -z : z;
    rad = root_rounded(ax * ax + ay * ay + az * az);
    o.radius = (rad > 64'hFFFF) ? 16'hFFFF : rad[15:0];
    o.azimuth = 0;
    o.polar = 0;
    m = (ax > ay) ? ax : ay;
    if (az > m) m = az;
    if (m != 0) begin
      sh = 0;
      while ((m << sh) < (longint'(1) << 57)) sh++;
      xs = x <<< sh; ys = y <<< sh; zs = z <<< sh;
      if (xs == 0 && ys == 0) begin
        o.polar = (zs > 0) ? 16'd0 : 16'h8000;
      end else begin
        rxy = xs;
        zk = 0;
        o.azimuth = angle_lsb(vector_angle(rxy, ys));
        if (zs != 0) begin
          zk = (zs < 0) ? -zs : zs;
          void'(vector_angle(zk, 0));
          if (zs < 0) zk = -zk;
        end
        o.polar = angle_lsb(vector_angle(zk, rxy));
      end
    end
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // watchdog on beats
  always @(posedge clk) begin
    if ((point.valid && point.ready) || (sphere.valid && sphere.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall pattern
  initial sphere.ready = 1'b0;
  always @(negedge clk) begin
    if (rst) sphere.ready <= 1'b0;
    else if (stall_free) sphere.ready <= 1'b1;
    else sphere.ready <= ($urandom_range(0, 3) != 0);
  end
  always @(negedge clk) begin
    if ($urandom_range(0, 499) == 0) stall_free = ~stall_free;
  end

  // result checker
  always @(posedge clk) begin
    sphere_t want;
    if (!rst && sphere.valid && sphere.ready) begin
      if (sphere_q.size() == 0) report("unexpected beat", 32'(sphere.radius), 32'd0);
      else begin
        want = sphere_q.pop_front();
        if (sphere.radius !== want.radius)
          report("radius", 32'(sphere.radius), 32'(want.radius));
        if (sphere.azimuth !== want.azimuth)
          report("azimuth", 32'(sphere.azimuth), 32'(want.azimuth));
        if (sphere.polar !== want.polar)
          report("polar", 32'(sphere.polar), 32'(want.polar));
      end
    end
  end

  int burst_left = 0;

  task automatic send_point(logic signed [15:0] x, y, z, bit typed, sphere_t res);
    sphere_t p;
    int      gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        point.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    point.valid   <= 1'b1;
    point.coord_x <= x;
    point.coord_y <= y;
    point.coord_z <= z;
    do @(posedge clk); while (!point.ready);
    p = to_sphere(x, y, z);
    if (typed && p.radius != res.radius)
      report("predictor vs table radius", 32'(p.radius), 32'(res.radius));
    if (typed && p.azimuth != res.azimuth)
      report("predictor vs table azimuth", 32'(p.azimuth), 32'(res.azimuth));
    if (typed && p.polar != res.polar)
      report("predictor vs table polar", 32'(p.polar), 32'(res.polar));
    sphere_q.push_back(typed ? res : p);
  endtask

  task automatic drain();
    @(negedge clk);
    point.valid <= 1'b0;
    burst_left = 0;
    while (sphere_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_band(logic [10:0] v);
    logic [APB_W-1:0] rd;
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {REG_ZERO_BAND, 2'b00}; pwdata <= {21'($urandom_range(0, 2 ** 21 - 1)), v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    band_cfg = v;
    @(negedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (rd[10:0] !== v) report("zero_band readback", rd, 32'(v));
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic logic signed [15:0] rnd_coord(int band);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return 16'((band + int'($urandom_range(0, 4)) - 2) *
                    ($urandom_range(0, 1) ? 1 : -1));
      2: return 16'sd0;
      3: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  point_row_t dir_rows[$];
  sphere_t    zero_res;

  initial begin
    logic signed [15:0] rx, ry, rz;
    point.valid = 1'b0;
    point.coord_x = '0; point.coord_y = '0; point.coord_z = '0;
    band_cfg = BAND_RESET;
    zero_res = '0;
    fill_atan_turn();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: axes, extremes, sign of z, band edge
    dir_rows = '{
      '{0, 0, 0, 1, '{16'd0, 16'd0, 16'd0}},
      '{0, 0, 5, 1, '{16'd5, 16'd0, 16'd0}},
      '{0, 0, -5, 1, '{16'd5, 16'd0, 16'h8000}},
      '{-32768, -32768, -32768, 0, zero_res},
      '{32767, 32767, 32767, 0, zero_res},
      '{5, 0, 0, 0, zero_res},
      '{0, 5, 0, 0, zero_res},
      '{-5, 0, 0, 0, zero_res},
      '{0, -5, 0, 0, zero_res},
      '{-32768, 0, 0, 0, zero_res},
      '{-32768, -1, 0, 0, zero_res},
      '{-32768, 1, 0, 0, zero_res},
      '{32767, -1, 1, 0, zero_res},
      '{1, 1, 1, 0, zero_res},
      '{-1, -1, -1, 0, zero_res},
      '{3, 4, 0, 0, zero_res},
      '{-3, 4, -12, 0, zero_res},
      '{100, -100, -32768, 0, zero_res},
      '{16'sh5555, 16'shAAAA, 16'sh0F0F, 0, zero_res}
    };
    foreach (dir_rows[i])
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed,
                 dir_rows[i].res);
    drain();
    // band of 1024 zeroes every coordinate below it; a magnitude of 1024 is kept
    write_band(11'd1024);
    send_point(1023, -1023, 512, 1, zero_res);
    send_point(-1024, 1023, 0, 0, zero_res);
    drain();

    // random phases over several band settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_band(11'd0);
        1: write_band(BAND_RESET);
        2: write_band(11'd2047);
        3: write_band(11'd1024);
        default: write_band(11'($urandom_range(0, 64)));
      endcase
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        rx = rnd_coord(int'(band_cfg));
        ry = rnd_coord(int'(band_cfg));
        rz = rnd_coord(int'(band_cfg));
        send_point(rx, ry, rz, 0, zero_res);
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
